@@ sv/lrsm_pkg.sv @@
// Shared widths, register indexes, rotation codes and inter-module structs for the mapper.
`default_nettype none
package lrsm_pkg;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int Q_W     = DIM_W;
   localparam int IDX_W   = 3;

   // largest dimension honored; register values above it are clamped
   localparam int MAX_DIM = 4096;

   // CSR register indexes
   localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROTATION      = 3'd2;
   localparam logic [IDX_W-1:0] REG_DEST_WIDTH    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DEST_HEIGHT   = 3'd4;

   // clockwise quarter turns
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Settled geometry; the user is to keep it constant while transactions flow, the block does not enforce it
   typedef struct packed {
      logic             ready;
      logic             err;
      logic [1:0]       rot;
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic [DIM_W-1:0] rw;
      logic [DIM_W-1:0] rh;
      logic [DIM_W-1:0] cw;
      logic [DIM_W-1:0] ch;
      logic [DIM_W-1:0] ox;
      logic [DIM_W-1:0] oy;
   } geom_type;

   // Partial division state handed from cell to cell
   typedef struct packed {
      logic              in_area;
      logic [PROD_W-1:0] rem_x;
      logic [PROD_W-1:0] rem_y;
      logic [Q_W-1:0]    q_x;
      logic [Q_W-1:0]    q_y;
   } div_type;

endpackage
`default_nettype wire

@@ sv/lrsm_geom.sv @@
// Configuration registers and the multi-cycle letterbox geometry sequencer.
`default_nettype none
module lrsm_geom (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_valid,
   input  wire  [lrsm_pkg::IDX_W-1:0]      csr_index,
   input  wire  [lrsm_pkg::DIM_W-1:0]      csr_data,
   output lrsm_pkg::geom_type              geom
);

   localparam int DW = lrsm_pkg::DIM_W;
   localparam int PW = lrsm_pkg::PROD_W;
   localparam int CW = $clog2(lrsm_pkg::Q_W);

   typedef enum logic [2:0] {
      G_MUL, G_PROD, G_SEL, G_DIV, G_FIN, G_OFS, G_IDLE
   } gstate_type;

   gstate_type    state_ff, state_in;
   logic [DW-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [DW-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [1:0]    rot_cfg_ff, rot_cfg_in;
   logic [1:0]    rot_ff, rot_in;
   logic [DW-1:0] sw_ff, sw_in, sh_ff, sh_in, dw_ff, dw_in, dh_ff, dh_in;
   logic [DW-1:0] rw_ff, rw_in, rh_ff, rh_in;
   logic [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [PW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          which_ff, which_in;
   logic [DW-1:0] cw_ff, cw_in, ch_ff, ch_in, ox_ff, ox_in, oy_ff, oy_in;
   logic          err_ff, err_in;
   logic [PW-1:0] step;
   logic          quarter;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
      if (32'(v) > 32'(lrsm_pkg::MAX_DIM)) begin
         return DW'(lrsm_pkg::MAX_DIM);
      end
      return v;
   endfunction

   assign step    = PW'(den_ff) << cnt_ff;
   assign quarter = (rot_cfg_ff == lrsm_pkg::ROT_90) || (rot_cfg_ff == lrsm_pkg::ROT_270);

   // Sequencer next state
   always_comb begin
      state_in   = state_ff;
      src_w_in   = src_w_ff;
      src_h_in   = src_h_ff;
      dst_w_in   = dst_w_ff;
      dst_h_in   = dst_h_ff;
      rot_cfg_in = rot_cfg_ff;
      rot_in     = rot_ff;
      sw_in      = sw_ff;
      sh_in      = sh_ff;
      dw_in      = dw_ff;
      dh_in      = dh_ff;
      rw_in      = rw_ff;
      rh_in      = rh_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      q_in       = q_ff;
      cnt_in     = cnt_ff;
      which_in   = which_ff;
      cw_in      = cw_ff;
      ch_in      = ch_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      err_in     = err_ff;

      unique case (state_ff)
         G_MUL: begin
            sw_in    = clamp_dim(src_w_ff);
            sh_in    = clamp_dim(src_h_ff);
            dw_in    = clamp_dim(dst_w_ff);
            dh_in    = clamp_dim(dst_h_ff);
            rw_in    = quarter ? clamp_dim(src_h_ff) : clamp_dim(src_w_ff);
            rh_in    = quarter ? clamp_dim(src_w_ff) : clamp_dim(src_h_ff);
            rot_in   = rot_cfg_ff;
            state_in = G_PROD;
         end
         G_PROD: begin
            p1_in    = PW'(dw_ff) * PW'(rh_ff);
            p2_in    = PW'(dh_ff) * PW'(rw_ff);
            state_in = G_SEL;
         end
         G_SEL: begin
            // width-limited when dw*rh <= dh*rw, else height-limited
            which_in = !(p1_ff <= p2_ff);
            num_in   = (p1_ff <= p2_ff) ? p1_ff : p2_ff;
            den_in   = (p1_ff <= p2_ff) ? rw_ff : rh_ff;
            q_in     = '0;
            cnt_in   = CW'(lrsm_pkg::Q_W - 1);
            state_in = G_DIV;
         end
         G_DIV: begin
            // restoring division, one quotient bit per cycle
            if (num_ff >= step) begin
               num_in = num_ff - step;
               q_in   = q_ff | (DW'(1) << cnt_ff);
            end
            if (cnt_ff == '0) begin
               state_in = G_FIN;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         G_FIN: begin
            cw_in    = which_ff ? q_ff : dw_ff;
            ch_in    = which_ff ? dh_ff : q_ff;
            state_in = G_OFS;
         end
         G_OFS: begin
            err_in   = (rw_ff == '0) || (rh_ff == '0) || (cw_ff == '0) || (ch_ff == '0);
            ox_in    = (dw_ff - cw_ff) >> 1;
            oy_in    = (dh_ff - ch_ff) >> 1;
            state_in = G_IDLE;
         end
         G_IDLE: begin
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_MUL;
         end
      endcase

      // register writes restart the geometry
      if (csr_valid) begin
         unique case (csr_index)
            lrsm_pkg::REG_SOURCE_WIDTH:  src_w_in   = csr_data;
            lrsm_pkg::REG_SOURCE_HEIGHT: src_h_in   = csr_data;
            lrsm_pkg::REG_ROTATION:      rot_cfg_in = csr_data[1:0];
            lrsm_pkg::REG_DEST_WIDTH:    dst_w_in   = csr_data;
            lrsm_pkg::REG_DEST_HEIGHT:   dst_h_in   = csr_data;
            default: ;
         endcase
         state_in = G_MUL;
      end
   end

   // State and geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= G_MUL;
         src_w_ff   <= DW'(640);
         src_h_ff   <= DW'(480);
         dst_w_ff   <= DW'(640);
         dst_h_ff   <= DW'(480);
         rot_cfg_ff <= lrsm_pkg::ROT_0;
      end else begin
         state_ff   <= state_in;
         src_w_ff   <= src_w_in;
         src_h_ff   <= src_h_in;
         dst_w_ff   <= dst_w_in;
         dst_h_ff   <= dst_h_in;
         rot_cfg_ff <= rot_cfg_in;
      end
      rot_ff   <= rot_in;
      sw_ff    <= sw_in;
      sh_ff    <= sh_in;
      dw_ff    <= dw_in;
      dh_ff    <= dh_in;
      rw_ff    <= rw_in;
      rh_ff    <= rh_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      which_ff <= which_in;
      cw_ff    <= cw_in;
      ch_ff    <= ch_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      err_ff   <= err_in;
   end

   assign geom.ready = (state_ff == G_IDLE);
   assign geom.err   = err_ff;
   assign geom.rot   = rot_ff;
   assign geom.sw    = sw_ff;
   assign geom.sh    = sh_ff;
   assign geom.rw    = rw_ff;
   assign geom.rh    = rh_ff;
   assign geom.cw    = cw_ff;
   assign geom.ch    = ch_ff;
   assign geom.ox    = ox_ff;
   assign geom.oy    = oy_ff;

   // a write always restarts the sequencer
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> state_ff == G_MUL)
      else $error("geometry not restarted after register write");

endmodule
`default_nettype wire

@@ sv/lrsm_div_cell.sv @@
// One cell of the division chain: resolves one quotient bit for the x and y lanes.
`default_nettype none
module lrsm_div_cell #(
   parameter int BIT = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [lrsm_pkg::DIM_W-1:0] den_x,
   input  wire  [lrsm_pkg::DIM_W-1:0] den_y,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  lrsm_pkg::div_type          in_data,
   output logic                       out_valid,
   input  wire                        out_ready,
   output lrsm_pkg::div_type          out_data
);

   localparam int PW = lrsm_pkg::PROD_W;

   logic              valid_ff;
   lrsm_pkg::div_type data_ff, data_in;
   logic [PW-1:0]     step_x, step_y;

   assign step_x   = PW'(den_x) << BIT;
   assign step_y   = PW'(den_y) << BIT;
   assign in_ready = !valid_ff || out_ready;

   // compare and subtract for each lane
   always_comb begin
      data_in = in_data;
      if (in_data.rem_x >= step_x) begin
         data_in.rem_x    = in_data.rem_x - step_x;
         data_in.q_x[BIT] = 1'b1;
      end
      if (in_data.rem_y >= step_y) begin
         data_in.rem_y    = in_data.rem_y - step_y;
         data_in.q_y[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ sv/letterbox_rotate_scale_mapper.sv @@
// Top level: letterbox test, scaling products, division cell chain and rotation output stage.
//
//  channel  | direction | signals
//  req_     | in        | req_valid, req_ready, req_dest_x, req_dest_y
//  rsp_     | out       | rsp_valid, rsp_ready, rsp_in_content, rsp_src_x, rsp_src_y,
//           |           | rsp_geometry_error
//  csr_     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// One transaction per cycle sustained while rsp_ready stays high and the geometry is settled;
// 16 register stages (an entry stage, a multiply stage, 13 division cells with one quotient
// bit each and the output stage). After reset and after every register write the geometry
// sequencer runs its states, including its iterative divider, with req_ready low. Each
// stage holds its transaction when the next one is full and stalled, so bubbles close up.
`default_nettype none
module letterbox_rotate_scale_mapper (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [lrsm_pkg::COORD_W-1:0] req_dest_x,
   input  wire  [lrsm_pkg::COORD_W-1:0] req_dest_y,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_in_content,
   output logic [lrsm_pkg::COORD_W-1:0] rsp_src_x,
   output logic [lrsm_pkg::COORD_W-1:0] rsp_src_y,
   output logic                         rsp_geometry_error,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [lrsm_pkg::IDX_W-1:0]   csr_index,
   input  wire  [lrsm_pkg::DIM_W-1:0]   csr_data
);

   localparam int DW = lrsm_pkg::DIM_W;
   localparam int PW = lrsm_pkg::PROD_W;
   localparam int QW = lrsm_pkg::Q_W;
   localparam int XW = lrsm_pkg::COORD_W;

   lrsm_pkg::geom_type geom;

   assign csr_ready = 1'b1;

   lrsm_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   // Entry stage: letterbox test and offset removal
   logic          a_valid_ff, a_ready;
   logic          a_inside_ff, a_inside_in;
   logic [DW-1:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic [DW:0]   lim_x, lim_y;
   logic [DW-1:0] x_ext, y_ext;
   logic          b_ready;

   assign x_ext       = {1'b0, req_dest_x};
   assign y_ext       = {1'b0, req_dest_y};
   assign lim_x       = {1'b0, geom.ox} + {1'b0, geom.cw};
   assign lim_y       = {1'b0, geom.oy} + {1'b0, geom.ch};
   assign a_inside_in = !geom.err
                        && (x_ext >= geom.ox) && ({1'b0, x_ext} < lim_x)
                        && (y_ext >= geom.oy) && ({1'b0, y_ext} < lim_y);
   assign a_dx_in     = x_ext - geom.ox;
   assign a_dy_in     = y_ext - geom.oy;
   assign a_ready     = !a_valid_ff || b_ready;
   assign req_ready   = geom.ready && a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid && geom.ready;
      end
      if (req_valid && req_ready) begin
         a_inside_ff <= a_inside_in;
         a_dx_ff     <= a_dx_in;
         a_dy_ff     <= a_dy_in;
      end
   end

   // Multiply stage: offsets times rotated source size feed the division chain
   logic              b_valid_ff;
   lrsm_pkg::div_type b_ff, b_in;
   logic              chain_valid [QW+1];
   logic              chain_ready [QW+1];
   lrsm_pkg::div_type chain_data  [QW+1];

   always_comb begin
      b_in         = '0;
      b_in.in_area = a_inside_ff;
      b_in.rem_x   = PW'(a_dx_ff) * PW'(geom.rw);
      b_in.rem_y   = PW'(a_dy_ff) * PW'(geom.rh);
   end

   assign b_ready = !b_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign chain_valid[0] = b_valid_ff;
   assign chain_data[0]  = b_ff;

   // Division cells, most significant quotient bit first
   for (genvar k = 0; k < QW; k++) begin : g_cell
      lrsm_div_cell #(.BIT(QW - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .den_x     (geom.cw),
         .den_y     (geom.ch),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // Output stage: undo the rotation
   logic          o_valid_ff, o_ready;
   logic          o_inside_ff;
   logic [XW-1:0] o_sx_ff, o_sx_in, o_sy_ff, o_sy_in;
   logic [DW-1:0] rx, ry, sx_full, sy_full;

   assign rx = chain_data[QW].q_x;
   assign ry = chain_data[QW].q_y;

   always_comb begin
      unique case (geom.rot)
         lrsm_pkg::ROT_90: begin
            sx_full = ry;
            sy_full = geom.sh - DW'(1) - rx;
         end
         lrsm_pkg::ROT_180: begin
            sx_full = geom.sw - DW'(1) - rx;
            sy_full = geom.sh - DW'(1) - ry;
         end
         lrsm_pkg::ROT_270: begin
            sx_full = geom.sw - DW'(1) - ry;
            sy_full = rx;
         end
         default: begin
            sx_full = rx;
            sy_full = ry;
         end
      endcase
      o_sx_in = chain_data[QW].in_area ? sx_full[XW-1:0] : '0;
      o_sy_in = chain_data[QW].in_area ? sy_full[XW-1:0] : '0;
   end

   assign o_ready         = !o_valid_ff || rsp_ready;
   assign chain_ready[QW] = o_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= chain_valid[QW];
      end
      if (o_ready && chain_valid[QW]) begin
         o_inside_ff <= chain_data[QW].in_area;
         o_sx_ff     <= o_sx_in;
         o_sy_ff     <= o_sy_in;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_in_content     = o_inside_ff;
   assign rsp_src_x          = o_sx_ff;
   assign rsp_src_y          = o_sy_ff;
   assign rsp_geometry_error = geom.err;

   a_err_no_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_geometry_error |-> !rsp_in_content)
      else $error("content flagged with geometry error");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_content |-> (rsp_src_x == '0) && (rsp_src_y == '0))
      else $error("border pixel with nonzero source position");

   a_accept_settled: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> $stable(geom.cw) && $stable(geom.ch))
      else $error("geometry moved under an accepted transaction");

endmodule
`default_nettype wire

@@ tb/sv/lrsm_checker.sv @@
// Scoreboard for the mapper: tracks registers, predicts each pixel mapping and compares results.
`default_nettype none
module lrsm_checker (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_ready,
   input  wire  [lrsm_pkg::COORD_W-1:0] req_dest_x,
   input  wire  [lrsm_pkg::COORD_W-1:0] req_dest_y,
   input  wire                          rsp_valid,
   input  wire                          rsp_ready,
   input  wire                          rsp_in_content,
   input  wire  [lrsm_pkg::COORD_W-1:0] rsp_src_x,
   input  wire  [lrsm_pkg::COORD_W-1:0] rsp_src_y,
   input  wire                          rsp_geometry_error,
   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  wire  [lrsm_pkg::IDX_W-1:0]   csr_index,
   input  wire  [lrsm_pkg::DIM_W-1:0]   csr_data,
   output int                           fail_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint DIM_LIMIT = 4096;

   typedef struct packed {
      logic                         in_content;
      logic [lrsm_pkg::COORD_W-1:0] src_x;
      logic [lrsm_pkg::COORD_W-1:0] src_y;
      logic                         geometry_error;
   } mapped_pixel_type;

   // shadow copy of the geometry registers
   logic [lrsm_pkg::DIM_W-1:0] cfg_src_w;
   logic [lrsm_pkg::DIM_W-1:0] cfg_src_h;
   logic [1:0]                 cfg_rot;
   logic [lrsm_pkg::DIM_W-1:0] cfg_dst_w;
   logic [lrsm_pkg::DIM_W-1:0] cfg_dst_h;

   mapped_pixel_type expected_pixels[$];

   function automatic longint clamp_dim(logic [lrsm_pkg::DIM_W-1:0] v);
      return (v > DIM_LIMIT) ? DIM_LIMIT : longint'(v);
   endfunction

   // letterbox, floor-scale and rotate one destination position
   function automatic mapped_pixel_type map_position(logic [lrsm_pkg::COORD_W-1:0] px,
                                                     logic [lrsm_pkg::COORD_W-1:0] py);
      mapped_pixel_type r;
      longint sw, sh, dw, dh, rw, rh, cw, ch, ox, oy, rx, ry, sx, sy, x, y;
      bit quarter;
      r = '0;
      x = px;
      y = py;
      sw = clamp_dim(cfg_src_w);
      sh = clamp_dim(cfg_src_h);
      dw = clamp_dim(cfg_dst_w);
      dh = clamp_dim(cfg_dst_h);
      quarter = (cfg_rot == lrsm_pkg::ROT_90) || (cfg_rot == lrsm_pkg::ROT_270);
      rw = quarter ? sh : sw;
      rh = quarter ? sw : sh;
      cw = 0;
      ch = 0;
      if (rw != 0 && rh != 0) begin
         if (dw * rh <= dh * rw) begin
            cw = dw;
            ch = dw * rh / rw;
         end else begin
            ch = dh;
            cw = dh * rw / rh;
         end
      end
      if (cw == 0 || ch == 0) begin
         r.geometry_error = 1'b1;
         return r;
      end
      ox = (dw - cw) / 2;
      oy = (dh - ch) / 2;
      // black border
      if (x < ox || x >= ox + cw || y < oy || y >= oy + ch) return r;
      rx = (x - ox) * rw / cw;
      ry = (y - oy) * rh / ch;
      case (cfg_rot)
         lrsm_pkg::ROT_90: begin
            sx = ry;
            sy = sh - 1 - rx;
         end
         lrsm_pkg::ROT_180: begin
            sx = sw - 1 - rx;
            sy = sh - 1 - ry;
         end
         lrsm_pkg::ROT_270: begin
            sx = sw - 1 - ry;
            sy = rx;
         end
         default: begin
            sx = rx;
            sy = ry;
         end
      endcase
      r.in_content = 1'b1;
      r.src_x = sx[lrsm_pkg::COORD_W-1:0];
      r.src_y = sy[lrsm_pkg::COORD_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      mapped_pixel_type want;
      if (reset) begin
         cfg_src_w <= 13'd640;
         cfg_src_h <= 13'd480;
         cfg_rot   <= lrsm_pkg::ROT_0;
         cfg_dst_w <= 13'd640;
         cfg_dst_h <= 13'd480;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lrsm_pkg::REG_SOURCE_WIDTH:  cfg_src_w <= csr_data;
               lrsm_pkg::REG_SOURCE_HEIGHT: cfg_src_h <= csr_data;
               lrsm_pkg::REG_ROTATION:      cfg_rot   <= csr_data[1:0];
               lrsm_pkg::REG_DEST_WIDTH:    cfg_dst_w <= csr_data;
               lrsm_pkg::REG_DEST_HEIGHT:   cfg_dst_h <= csr_data;
               default: ;
            endcase
         end
         // accepted position
         if (req_valid && req_ready) expected_pixels.push_back(map_position(req_dest_x, req_dest_y));
         // accepted result
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual src %0d,%0d",
                        $time, rsp_src_x, rsp_src_y);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("in_content", want.in_content, rsp_in_content);
               check_field("src_x", want.src_x, rsp_src_x);
               check_field("src_y", want.src_y, rsp_src_y);
               check_field("geometry_error", want.geometry_error, rsp_geometry_error);
            end
         end
         pending_count = expected_pixels.size();
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/tb_letterbox_rotate_scale_mapper.sv @@
// Testbench top: clock, reset, register phases, position stimulus and the final verdict.
`default_nettype none
module tb_letterbox_rotate_scale_mapper;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [lrsm_pkg::COORD_W-1:0] req_dest_x = '0;
   logic [lrsm_pkg::COORD_W-1:0] req_dest_y = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_in_content;
   logic [lrsm_pkg::COORD_W-1:0] rsp_src_x;
   logic [lrsm_pkg::COORD_W-1:0] rsp_src_y;
   logic                         rsp_geometry_error;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [lrsm_pkg::IDX_W-1:0]   csr_index = '0;
   logic [lrsm_pkg::DIM_W-1:0]   csr_data = '0;
   int                           fail_count;
   int                           pending_count;
   bit                           steady = 1'b0;

   letterbox_rotate_scale_mapper dut (.*);

   lrsm_checker u_checker (.*);

   always #4 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(99) >= 21);

   // one position transaction; valid stays up across back-to-back items
   task automatic send_position(int x, int y);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_dest_x <= x[lrsm_pkg::COORD_W-1:0];
      req_dest_y <= y[lrsm_pkg::COORD_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [lrsm_pkg::IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[lrsm_pkg::DIM_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // write all registers, hit corners of the destination, then random positions
   task automatic run_phase(int sw, int sh, int rot, int dw, int dh, int n);
      int wx, wy;
      write_reg(lrsm_pkg::REG_SOURCE_WIDTH, sw);
      write_reg(lrsm_pkg::REG_SOURCE_HEIGHT, sh);
      write_reg(lrsm_pkg::REG_ROTATION, rot);
      write_reg(lrsm_pkg::REG_DEST_WIDTH, dw);
      write_reg(lrsm_pkg::REG_DEST_HEIGHT, dh);
      wx = (dw + 8 > 4095) ? 4095 : dw + 8;
      wy = (dh + 8 > 4095) ? 4095 : dh + 8;
      send_position(0, 0);
      send_position(dw > 0 ? dw - 1 : 0, dh > 0 ? dh - 1 : 0);
      send_position(dw / 2, dh / 2);
      send_position(4095, 4095);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 80) send_position($urandom_range(wx), $urandom_range(wy));
         else send_position($urandom_range(4095), $urandom_range(4095));
      end
      drain();
   endtask

   initial begin
      int rot;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, no writes
      send_position(0, 0);
      send_position(639, 479);
      send_position(640, 0);
      send_position(0, 480);
      send_position(320, 240);
      send_position(4095, 0);
      send_position(0, 4095);
      send_position(4095, 4095);
      // pause mid-stream until every result is back
      drain();
      send_position(1, 1);
      send_position(638, 478);
      drain();

      // unused register index must be ignored
      write_reg(3'd7, 13'h1FFF);

      // extremes, every rotation, collapsed and zero geometry
      run_phase(1, 1, lrsm_pkg::ROT_0, 1, 1, 6);
      run_phase(4096, 4096, lrsm_pkg::ROT_90, 4096, 4096, 20);
      run_phase(8191, 8191, lrsm_pkg::ROT_180, 8191, 8191, 20);
      run_phase(100, 50, lrsm_pkg::ROT_270, 64, 64, 20);
      run_phase(0, 480, lrsm_pkg::ROT_90, 640, 480, 6);
      run_phase(640, 480, lrsm_pkg::ROT_0, 0, 480, 6);
      run_phase(4096, 1, lrsm_pkg::ROT_0, 16, 4096, 6);
      run_phase(1, 4096, lrsm_pkg::ROT_180, 4096, 1, 6);

      // random geometries, one phase without any idling
      for (int p = 0; p < 14; p++) begin
         steady = (p == 4);
         rot = $urandom_range(3);
         if ($urandom_range(99) < 70)
            run_phase($urandom_range(1, 96), $urandom_range(1, 96), rot,
                      $urandom_range(1, 128), $urandom_range(1, 128), 95);
         else
            run_phase($urandom_range(8191), $urandom_range(8191), rot,
                      $urandom_range(8191), $urandom_range(8191), 95);
      end
      steady = 1'b0;

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
